FILE: rtl/core/perspective_canvas_projection_unit_defines.svh
// ----------------------------------------------------------------------------
// perspective canvas projection assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_CANVAS_PROJECTION_UNIT_DEFINES_SVH
`define PERSPECTIVE_CANVAS_PROJECTION_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// implication style check, disabled while reset is low
`define PCP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression that must never hold
`define PCP_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PCP_ASSERT(label, clk, rst_n, prop, msg)
`define PCP_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/core/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// shared widths, types and helpers of the perspective canvas projection
// ----------------------------------------------------------------------------
`default_nettype none
package pcp_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CRD_W     = 32;
	localparam int DIV_W     = CRD_W + FRAC_BITS;   // dividend and quotient
	localparam int DEN_W     = CRD_W + 1;           // |eye - z| up to 2^32 - 1
	localparam int MAG_W     = 57;                  // clamp at 2^56
	localparam int SUM_W     = MAG_W + 2;
	localparam int IDX_W     = 3;
	localparam int PIPE_LAT  = 1 + DIV_W + 2 + 3;

	localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (MAG_W - 1);
	localparam logic [63:0] HI_LIM = 64'(1) << (MAG_W - 1 - (32 - FRAC_BITS));

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_SCALE  = 3'd2,
		REG_EYE    = 3'd3,
		REG_PERSP  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] px;
		logic signed [CRD_W-1:0] py;
		logic                    flip;
		logic                    fneg;
		logic                    zero;
	} side_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DIV_W-1:0] nq;
		logic [DEN_W-1:0] den;
		side_t            side;
	} lane_t;

	function automatic logic [CRD_W-1:0] mag32(input logic signed [CRD_W-1:0] v);
		return v[CRD_W-1] ? CRD_W'(-v) : CRD_W'(v);
	endfunction

	// min((hi*2^32 + lo) >> FRAC_BITS, 2^56)
	function automatic logic [MAG_W-1:0] mul_combine(input logic [63:0] hi,
			input logic [63:0] lo);
		logic [65:0] r;
		r = (66'(hi) << (32 - FRAC_BITS)) + 66'(lo >> FRAC_BITS);
		if (hi > HI_LIM || r > 66'(MAG_CAP))
			return MAG_CAP;
		return r[MAG_W-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/perspective_canvas_projection_unit.sv
// ----------------------------------------------------------------------------
// perspective_canvas_projection_unit
// projects Q16.16 3-D points onto a canvas with an optional depth factor
// ----------------------------------------------------------------------------
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------
// point     | in        | start && !busy         | point_x/y/z, flip_y
// result    | out       | done strobe, 1 cycle   | canvas_x/y, range_error
// config    | in        | cfg_valid && cfg_ready | cfg_index, cfg_data
//
// one point is taken every clock cycle; busy is never raised
// each result passes the front stage, the
// 48 step division pipeline, then the scale and projection stages
// reset clears all stage valid bits and loads the config register defaults
// the receiver cannot stall, so nothing in the pipe ever waits
// ----------------------------------------------------------------------------
`default_nettype none
`include "perspective_canvas_projection_unit_defines.svh"
module perspective_canvas_projection_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [31:0]        point_x,
	input  wire logic signed [31:0]        point_y,
	input  wire logic signed [31:0]        point_z,
	input  wire logic                      flip_y,
	output logic                           done,
	output logic signed [31:0]             canvas_x,
	output logic signed [31:0]             canvas_y,
	output logic                           range_error,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [pcp_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [31:0]               cfg_data
);
	// configuration registers
	logic [15:0]        width_q;
	logic [15:0]        height_q;
	logic [31:0]        scale_q;
	logic signed [31:0] eye_q;
	logic               persp_q;

	// front stage signals
	logic signed [32:0] den;
	logic               den_zero;
	logic               valid_s1;
	pcp_pkg::lane_t     lane_s1;
	pcp_pkg::lane_t     lane_nxt;

	// divider to scale
	logic               div_valid;
	pcp_pkg::lane_t     div_lane;
	logic               sc_valid;
	logic [pcp_pkg::MAG_W-1:0] sc_gm;
	pcp_pkg::side_t     sc_side;
	logic [31:0]        px_out, py_out;
	logic               zero_out;

	// check helpers
	logic               accept;
	logic               sat_both;

	// the pipe never backs up, so both channels are always open
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// config register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd640;
			height_q <= 16'd480;
			scale_q  <= 32'd65536;
			eye_q    <= 32'sd655360;
			persp_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pcp_pkg::cfg_reg_t'(cfg_index))
				pcp_pkg::REG_WIDTH:  width_q  <= cfg_data[15:0];
				pcp_pkg::REG_HEIGHT: height_q <= cfg_data[15:0];
				pcp_pkg::REG_SCALE:  scale_q  <= cfg_data;
				pcp_pkg::REG_EYE:    eye_q    <= cfg_data;
				pcp_pkg::REG_PERSP:  persp_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front stage: denominator, magnitudes and signs
	// with perspective off the divider sees 2^FRAC_BITS / 1, which gives factor one
	// a zero denominator also divides by one and is flagged to the end
	always_comb begin
		den      = 33'(eye_q) - 33'(point_z);
		den_zero = persp_q && (den == 33'sd0);
		lane_nxt.rem       = '0;
		lane_nxt.side.px   = point_x;
		lane_nxt.side.py   = point_y;
		lane_nxt.side.flip = flip_y;
		lane_nxt.side.zero = den_zero;
		if (persp_q && !den_zero) begin
			lane_nxt.nq        = pcp_pkg::DIV_W'(pcp_pkg::mag32(eye_q)) << pcp_pkg::FRAC_BITS;
			lane_nxt.den       = den[32] ? 33'(-den) : 33'(den);
			lane_nxt.side.fneg = eye_q[31] ^ den[32];
		end else begin
			lane_nxt.nq        = pcp_pkg::DIV_W'(1) << pcp_pkg::FRAC_BITS;
			lane_nxt.den       = pcp_pkg::DEN_W'(1);
			lane_nxt.side.fneg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane_nxt;
	end

	// depth factor division, one quotient bit per stage
	pcp_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_lane   (lane_s1),
		.out_valid (div_valid),
		.out_lane  (div_lane)
	);

	// overall factor g = f * view_scale
	pcp_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (div_valid),
		.fm         (div_lane.nq),
		.in_side    (div_lane.side),
		.view_scale (scale_q),
		.out_valid  (sc_valid),
		.gm         (sc_gm),
		.out_side   (sc_side)
	);

	// coordinate products and canvas offset
	pcp_project u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.gm        (sc_gm),
		.in_side   (sc_side),
		.width_px  (width_q),
		.height_px (height_q),
		.out_valid (done),
		.x_out     (px_out),
		.y_out     (py_out),
		.err_out   (range_error),
		.zero_out  (zero_out)
	);

	assign canvas_x = px_out;
	assign canvas_y = py_out;

	assign accept   = start && !busy;
	assign sat_both = range_error && canvas_x == 32'sh7FFF_FFFF && canvas_y == 32'sh7FFF_FFFF;

	`PCP_ASSERT(a_fixed_latency, clk, arst_n, accept |-> ##(pcp_pkg::PIPE_LAT) done, "late result")
	`PCP_ASSERT(a_zero_den_sat, clk, arst_n, done && zero_out |-> sat_both, "zero den not saturated")
	`PCP_NEVER(a_rem_bound, clk, arst_n, div_valid && (div_lane.rem >= div_lane.den), "bad remainder")
endmodule
`default_nettype wire

FILE: rtl/core/pcp_div_stage.sv
// ----------------------------------------------------------------------------
// pcp_div_stage
// one restoring division step, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module pcp_div_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  pcp_pkg::lane_t     in_lane,
	output logic               out_valid,
	output pcp_pkg::lane_t     out_lane
);
	logic [pcp_pkg::DEN_W:0]   trial;
	logic                      ge;
	logic [pcp_pkg::DEN_W:0]   diff;
	pcp_pkg::lane_t            nxt;

	always_comb begin
		trial = {in_lane.rem, in_lane.nq[pcp_pkg::DIV_W-1]};
		ge    = trial >= {1'b0, in_lane.den};
		diff  = trial - {1'b0, in_lane.den};
		nxt   = in_lane;
		nxt.rem = ge ? diff[pcp_pkg::DEN_W-1:0] : trial[pcp_pkg::DEN_W-1:0];
		nxt.nq  = {in_lane.nq[pcp_pkg::DIV_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_lane <= nxt;
	end
endmodule
`default_nettype wire

FILE: rtl/core/pcp_divider.sv
// ----------------------------------------------------------------------------
// pcp_divider
// fully pipelined radix-2 divider, one stage per quotient bit
// ----------------------------------------------------------------------------
`default_nettype none
module pcp_divider (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  pcp_pkg::lane_t     in_lane,
	output logic               out_valid,
	output pcp_pkg::lane_t     out_lane
);
	logic           v_chain [pcp_pkg::DIV_W+1];
	pcp_pkg::lane_t l_chain [pcp_pkg::DIV_W+1];

	assign v_chain[0] = in_valid;
	assign l_chain[0] = in_lane;

	for (genvar g = 0; g < pcp_pkg::DIV_W; g++) begin : g_step
		pcp_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_chain[g]),
			.in_lane   (l_chain[g]),
			.out_valid (v_chain[g+1]),
			.out_lane  (l_chain[g+1])
		);
	end

	assign out_valid = v_chain[pcp_pkg::DIV_W];
	assign out_lane  = l_chain[pcp_pkg::DIV_W];
endmodule
`default_nettype wire

FILE: rtl/core/pcp_scale.sv
// ----------------------------------------------------------------------------
// pcp_scale
// depth factor times view scale, split product and clamp over two stages
// ----------------------------------------------------------------------------
`default_nettype none
module pcp_scale (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [pcp_pkg::DIV_W-1:0]  fm,
	input  pcp_pkg::side_t                  in_side,
	input  wire logic [31:0]                view_scale,
	output logic                            out_valid,
	output logic [pcp_pkg::MAG_W-1:0]       gm,
	output pcp_pkg::side_t                  out_side
);
	logic                   valid_s1;
	logic [63:0]            hi_s1;
	logic [63:0]            lo_s1;
	pcp_pkg::side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		hi_s1    <= 64'(fm[pcp_pkg::DIV_W-1:32]) * 64'(view_scale);
		lo_s1    <= 64'(fm[31:0]) * 64'(view_scale);
		side_s1  <= in_side;
		gm       <= pcp_pkg::mul_combine(hi_s1, lo_s1);
		out_side <= side_s1;
	end
endmodule
`default_nettype wire

FILE: rtl/core/pcp_project.sv
// ----------------------------------------------------------------------------
// pcp_project
// coordinate products, signs, centre offset and saturation
// ----------------------------------------------------------------------------
`default_nettype none
module pcp_project (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [pcp_pkg::MAG_W-1:0]  gm,
	input  pcp_pkg::side_t                  in_side,
	input  wire logic [15:0]                width_px,
	input  wire logic [15:0]                height_px,
	output logic                            out_valid,
	output logic [31:0]                     x_out,
	output logic [31:0]                     y_out,
	output logic                            err_out,
	output logic                            zero_out
);
	localparam logic signed [pcp_pkg::SUM_W-1:0] S_MAX = pcp_pkg::SUM_W'(32'h7FFF_FFFF);
	localparam logic signed [pcp_pkg::SUM_W-1:0] S_MIN = -(pcp_pkg::SUM_W'(64'h8000_0000));

	logic [31:0]                   ax, ay;
	logic                          valid_s1, valid_s2;
	logic [63:0]                   xhi_s1, xlo_s1, yhi_s1, ylo_s1;
	logic                          nx_s1, ny_s1, zero_s1, nx_s2, ny_s2, zero_s2;
	logic [pcp_pkg::MAG_W-1:0]     xm_s2, ym_s2;
	logic signed [pcp_pkg::SUM_W-1:0] cx, cy, sx, sy;
	logic                          ex, ey;

	always_comb begin
		ax = pcp_pkg::mag32(in_side.px);
		ay = pcp_pkg::mag32(in_side.py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	// stage 1: split products
	always_ff @(posedge clk) begin
		xhi_s1  <= 64'(gm[pcp_pkg::MAG_W-1:32]) * 64'(ax);
		xlo_s1  <= 64'(gm[31:0]) * 64'(ax);
		yhi_s1  <= 64'(gm[pcp_pkg::MAG_W-1:32]) * 64'(ay);
		ylo_s1  <= 64'(gm[31:0]) * 64'(ay);
		nx_s1   <= in_side.px[31] ^ in_side.fneg;
		ny_s1   <= in_side.py[31] ^ in_side.fneg ^ ~in_side.flip;
		zero_s1 <= in_side.zero;
	end

	// stage 2: clamp magnitudes
	always_ff @(posedge clk) begin
		xm_s2   <= pcp_pkg::mul_combine(xhi_s1, xlo_s1);
		ym_s2   <= pcp_pkg::mul_combine(yhi_s1, ylo_s1);
		nx_s2   <= nx_s1;
		ny_s2   <= ny_s1;
		zero_s2 <= zero_s1;
	end

	// stage 3: centre offset and saturation
	always_comb begin
		cx = pcp_pkg::SUM_W'(width_px) <<< (pcp_pkg::FRAC_BITS - 1);
		cy = pcp_pkg::SUM_W'(height_px) <<< (pcp_pkg::FRAC_BITS - 1);
		sx = nx_s2 ? cx - pcp_pkg::SUM_W'(xm_s2) : cx + pcp_pkg::SUM_W'(xm_s2);
		sy = ny_s2 ? cy - pcp_pkg::SUM_W'(ym_s2) : cy + pcp_pkg::SUM_W'(ym_s2);
		ex = (sx > S_MAX) || (sx < S_MIN);
		ey = (sy > S_MAX) || (sy < S_MIN);
	end

	always_ff @(posedge clk) begin
		zero_out <= zero_s2;
		if (zero_s2) begin
			x_out   <= 32'h7FFF_FFFF;
			y_out   <= 32'h7FFF_FFFF;
			err_out <= 1'b1;
		end else begin
			x_out   <= (sx > S_MAX) ? 32'h7FFF_FFFF :
				(sx < S_MIN) ? 32'h8000_0000 : sx[31:0];
			y_out   <= (sy > S_MAX) ? 32'h7FFF_FFFF :
				(sy < S_MIN) ? 32'h8000_0000 : sy[31:0];
			err_out <= ex | ey;
		end
	end
endmodule
`default_nettype wire
